// ===== hdl/fpd_pkg.sv =====
// Shared types, codes and constants of the flight phase detector.
package fpd_pkg;

    localparam logic [2:0] STAGE_PAD    = 3'd0;
    localparam logic [2:0] STAGE_BOOST  = 3'd1;
    localparam logic [2:0] STAGE_COAST  = 3'd2;
    localparam logic [2:0] STAGE_DROGUE = 3'd3;
    localparam logic [2:0] STAGE_MAIN   = 3'd4;
    localparam logic [2:0] STAGE_LANDED = 3'd5;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_FLIGHT = 2'd1;
    localparam logic [1:0] MODE_GROUND = 2'd2;

    localparam logic [2:0] CFG_LAUNCH_ACCEL = 3'd0;
    localparam logic [2:0] CFG_COAST_ACCEL  = 3'd1;
    localparam logic [2:0] CFG_MAIN_ALT     = 3'd2;
    localparam logic [2:0] CFG_LAND_ALT     = 3'd3;
    localparam logic [2:0] CFG_LAND_VEL     = 3'd4;
    localparam logic [2:0] CFG_HOLD_TICKS   = 3'd5;
    localparam logic [2:0] CFG_BACKUP_MS    = 3'd6;
    localparam logic [2:0] CFG_MIN_FIX      = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] INDICATOR_MS  = 32'd2000;
    localparam logic [31:0] DROGUE_MIN_MS = 32'd5000;
    localparam logic [31:0] MAIN_MIN_MS   = 32'd15000;
    localparam logic [31:0] LAND_MIN_MS   = 32'd25000;
    localparam logic [31:0] COUNT_MIN_MS  = 32'd30000;
    localparam logic [7:0]  TICKS_MAX     = 8'd255;

    typedef struct packed {
        logic        [31:0] time_ms;
        logic signed [23:0] raw_accel_z;
        logic signed [23:0] accel_z;
        logic signed [23:0] vel_z;
        logic signed [31:0] pos_z;
        logic signed [31:0] baro_alt;
        logic        [3:0]  fix_quality;
    } t_in_item;

    typedef struct packed {
        logic        [2:0]  stage;
        logic        [31:0] since_launch_ms;
        logic signed [31:0] apogee;
        logic        [1:0]  record_mode;
        logic               launch_indicator;
        logic               frozen;
    } t_out_item;

    typedef struct packed {
        logic        [16:0] launch_accel_limit;
        logic        [16:0] coast_accel_limit;
        logic        [23:0] main_deploy_altitude;
        logic        [23:0] landing_altitude;
        logic signed [17:0] landing_velocity;
        logic        [7:0]  landing_hold_ticks;
        logic        [31:0] backup_timeout_ms;
        logic        [3:0]  min_fix_quality;
    } t_cfg;

endpackage

// ===== hdl/fpd_cfg.sv =====
// Configuration register file of the flight phase detector.
module fpd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output fpd_pkg::t_cfg                 o_cfg
);
    import fpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.launch_accel_limit   <= 17'd1900;
            r_cfg.coast_accel_limit    <= 17'd500;
            r_cfg.main_deploy_altitude <= 24'd25000;
            r_cfg.landing_altitude     <= 24'd2000;
            r_cfg.landing_velocity     <= -18'sd50;
            r_cfg.landing_hold_ticks   <= 8'd50;
            r_cfg.backup_timeout_ms    <= 32'd180000000;
            r_cfg.min_fix_quality      <= 4'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LAUNCH_ACCEL: r_cfg.launch_accel_limit   <= i_cfg_data[16:0];
                CFG_COAST_ACCEL:  r_cfg.coast_accel_limit    <= i_cfg_data[16:0];
                CFG_MAIN_ALT:     r_cfg.main_deploy_altitude <= i_cfg_data[23:0];
                CFG_LAND_ALT:     r_cfg.landing_altitude     <= i_cfg_data[23:0];
                CFG_LAND_VEL:     r_cfg.landing_velocity     <= $signed(i_cfg_data[17:0]);
                CFG_HOLD_TICKS:   r_cfg.landing_hold_ticks   <= i_cfg_data[7:0];
                CFG_BACKUP_MS:    r_cfg.backup_timeout_ms    <= i_cfg_data[31:0];
                CFG_MIN_FIX:      r_cfg.min_fix_quality      <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/fpd_engine.sv =====
// Flight stage state and its per-tick update logic.
module fpd_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  fpd_pkg::t_in_item   i_item,
    input  fpd_pkg::t_cfg       i_cfg,
    output fpd_pkg::t_out_item  o_result
);
    import fpd_pkg::*;

    logic        [2:0]  r_stage, n_stage;
    logic        [31:0] r_launch_time, n_launch_time;
    logic        [31:0] r_elapsed, n_elapsed;
    logic signed [31:0] r_apogee, n_apogee;
    logic        [7:0]  r_ticks, n_ticks;
    logic        [1:0]  r_mode, n_mode;

    logic        frozen_now;
    logic        indicator;
    logic [31:0] el;
    logic        launch_ok;
    logic        coast_ok;
    logic        drogue_ok;
    logic        main_ok;
    logic        land_ok;

    assign frozen_now = (r_stage == STAGE_LANDED) && (r_ticks > i_cfg.landing_hold_ticks);
    assign indicator  = (r_elapsed != 32'd0) && (r_elapsed < INDICATOR_MS);
    assign el         = (i_item.time_ms >= r_launch_time) ? (i_item.time_ms - r_launch_time)
                                                           : 32'd0;

    assign launch_ok = ($signed({i_item.raw_accel_z[23], i_item.raw_accel_z})
                        > $signed({8'd0, i_cfg.launch_accel_limit}))
                       && (i_item.fix_quality > i_cfg.min_fix_quality);
    assign coast_ok  = $signed({i_item.accel_z[23], i_item.accel_z})
                       < $signed({8'd0, i_cfg.coast_accel_limit});
    assign drogue_ok = (i_item.vel_z <= 24'sd0) && (el > DROGUE_MIN_MS);
    assign main_ok   = ($signed({i_item.pos_z[31], i_item.pos_z})
                        < $signed({9'd0, i_cfg.main_deploy_altitude}))
                       && (el > MAIN_MIN_MS);
    assign land_ok   = (i_item.vel_z > 24'(i_cfg.landing_velocity))
                       && ($signed({i_item.baro_alt[31], i_item.baro_alt})
                           < $signed({9'd0, i_cfg.landing_altitude}))
                       && (el > LAND_MIN_MS);

    always_comb begin
        n_stage       = r_stage;
        n_launch_time = r_launch_time;
        n_elapsed     = r_elapsed;
        n_apogee      = r_apogee;
        n_ticks       = r_ticks;
        n_mode        = r_mode;
        if (!frozen_now) begin
            n_elapsed = el;
            unique case (r_stage)
                STAGE_PAD: begin
                    if (launch_ok) begin
                        n_stage       = STAGE_BOOST;
                        n_mode        = MODE_FLIGHT;
                        n_launch_time = i_item.time_ms;
                        n_elapsed     = 32'd0;
                    end
                end
                STAGE_BOOST: begin
                    if (coast_ok) n_stage = STAGE_COAST;
                end
                STAGE_COAST: begin
                    if (drogue_ok) n_stage = STAGE_DROGUE;
                end
                STAGE_DROGUE: begin
                    if (main_ok) n_stage = STAGE_MAIN;
                end
                STAGE_MAIN: begin
                    if (land_ok) n_stage = STAGE_LANDED;
                end
                STAGE_LANDED: begin
                    if (el > COUNT_MIN_MS) begin
                        if (r_ticks != TICKS_MAX) n_ticks = r_ticks + 8'd1;
                        if (r_ticks >= i_cfg.landing_hold_ticks) n_mode = MODE_GROUND;
                    end
                end
                default: begin
                end
            endcase
            if (n_stage < STAGE_DROGUE) n_apogee = i_item.pos_z;
            if ((n_stage > STAGE_PAD) && (n_stage < STAGE_LANDED)
                && (n_elapsed > i_cfg.backup_timeout_ms)) begin
                n_stage = STAGE_LANDED;
                n_mode  = MODE_GROUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage       <= STAGE_PAD;
            r_launch_time <= 32'd0;
            r_elapsed     <= 32'd0;
            r_apogee      <= 32'sd0;
            r_ticks       <= 8'd0;
            r_mode        <= MODE_IDLE;
        end else if (i_update) begin
            r_stage       <= n_stage;
            r_launch_time <= n_launch_time;
            r_elapsed     <= n_elapsed;
            r_apogee      <= n_apogee;
            r_ticks       <= n_ticks;
            r_mode        <= n_mode;
        end
    end

    always_comb begin
        o_result.stage            = n_stage;
        o_result.since_launch_ms  = n_elapsed;
        o_result.apogee           = n_apogee;
        o_result.record_mode      = n_mode;
        o_result.launch_indicator = indicator;
        o_result.frozen           = (n_stage == STAGE_LANDED)
                                    && (n_ticks > i_cfg.landing_hold_ticks);
    end

`ifndef SYNTHESIS
    // The pad stage and the idle record mode are entered and left together.
    a_pad_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == STAGE_PAD) == (r_mode == MODE_IDLE))
        else $error("pad stage and idle mode disagree");

    // A frozen block leaves its whole state untouched.
    a_frozen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frozen_now && i_update) |=> ($stable(r_stage) && $stable(r_elapsed)
                                      && $stable(r_apogee) && $stable(r_mode)))
        else $error("state changed while frozen");

    // The stage never moves backwards.
    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_update |=> (r_stage >= $past(r_stage)))
        else $error("stage moved backwards");
`endif

endmodule

// ===== hdl/flight_phase_detector.sv =====
// Top level of the flight phase detector: input and result registers around the update logic.
// A tick waits in the input register; stage state updates as it enters the result register.
// Throughput: one input transfer per cycle while the result register is not stalled.
// A full result register that is stalled holds one more tick in the input register before stalling.
// Reset (synchronous, active low) restores the register defaults and the pad stage with idle mode.
// Frozen ticks still produce a result carrying the held values.
module flight_phase_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  fpd_pkg::t_in_item             i_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output fpd_pkg::t_out_item            o_out,
    input  logic                          i_cfg_we,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fpd_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item eng_result;
    t_cfg      cfg;
    logic      advance;
    logic      in_fire;
    logic      process;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign in_fire = i_valid && !o_stall;
    assign process = r_in_valid && advance;

    fpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fpd_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (process),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            if (process) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in;
        end
        if (process) begin
            r_out <= eng_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

// ===== verif/tb_flight_phase_detector.sv =====
// Self-checking testbench for the flight phase detector: a stage predictor and randomized flights.
module tb_flight_phase_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import fpd_pkg::*;

    class flight_tracker;
        t_cfg               limits;
        logic [2:0]         stage;
        logic [31:0]        launch_at;
        logic [31:0]        elapsed;
        logic signed [31:0] apogee;
        logic [7:0]         ticks;
        logic [1:0]         mode;
        t_out_item          awaited[$];
        int                 errors;
        int                 seen;

        function new();
            limits.launch_accel_limit   = 17'd1900;
            limits.coast_accel_limit    = 17'd500;
            limits.main_deploy_altitude = 24'd25000;
            limits.landing_altitude     = 24'd2000;
            limits.landing_velocity     = -18'sd50;
            limits.landing_hold_ticks   = 8'd50;
            limits.backup_timeout_ms    = 32'd180000000;
            limits.min_fix_quality      = 4'd4;
            stage     = STAGE_PAD;
            launch_at = '0;
            elapsed   = '0;
            apogee    = '0;
            ticks     = '0;
            mode      = MODE_IDLE;
            errors    = 0;
            seen      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_LAUNCH_ACCEL: limits.launch_accel_limit   = data[16:0];
                CFG_COAST_ACCEL:  limits.coast_accel_limit    = data[16:0];
                CFG_MAIN_ALT:     limits.main_deploy_altitude = data[23:0];
                CFG_LAND_ALT:     limits.landing_altitude     = data[23:0];
                CFG_LAND_VEL:     limits.landing_velocity     = data[17:0];
                CFG_HOLD_TICKS:   limits.landing_hold_ticks   = data[7:0];
                CFG_BACKUP_MS:    limits.backup_timeout_ms    = data;
                CFG_MIN_FIX:      limits.min_fix_quality      = data[3:0];
                default: ;
            endcase
        endfunction

        function bit is_frozen();
            return stage == STAGE_LANDED && ticks > limits.landing_hold_ticks;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function t_out_item advance_flight(t_in_item tick);
            t_out_item   r;
            logic [31:0] el;
            logic [7:0]  old_ticks;
            bit          indicator;
            int          raw_acc;
            int          acc;
            int          vel;
            int          pos;
            int          baro;
            indicator = elapsed > 0 && elapsed < INDICATOR_MS;
            raw_acc   = $signed(tick.raw_accel_z);
            acc       = $signed(tick.accel_z);
            vel       = $signed(tick.vel_z);
            pos       = $signed(tick.pos_z);
            baro      = $signed(tick.baro_alt);
            if (!is_frozen()) begin
                el = (tick.time_ms >= launch_at) ? tick.time_ms - launch_at : '0;
                elapsed = el;
                case (stage)
                    STAGE_PAD: begin
                        if (raw_acc > int'(limits.launch_accel_limit) &&
                            tick.fix_quality > limits.min_fix_quality) begin
                            stage     = STAGE_BOOST;
                            mode      = MODE_FLIGHT;
                            launch_at = tick.time_ms;
                            elapsed   = '0;
                        end
                    end
                    STAGE_BOOST: begin
                        if (acc < int'(limits.coast_accel_limit))
                            stage = STAGE_COAST;
                    end
                    STAGE_COAST: begin
                        if (vel <= 0 && el > DROGUE_MIN_MS)
                            stage = STAGE_DROGUE;
                    end
                    STAGE_DROGUE: begin
                        if (pos < int'(limits.main_deploy_altitude) && el > MAIN_MIN_MS)
                            stage = STAGE_MAIN;
                    end
                    STAGE_MAIN: begin
                        if (vel > int'(limits.landing_velocity) &&
                            baro < int'(limits.landing_altitude) && el > LAND_MIN_MS)
                            stage = STAGE_LANDED;
                    end
                    STAGE_LANDED: begin
                        if (el > COUNT_MIN_MS) begin
                            old_ticks = ticks;
                            if (ticks < TICKS_MAX)
                                ticks++;
                            if (old_ticks >= limits.landing_hold_ticks)
                                mode = MODE_GROUND;
                        end
                    end
                    default: ;
                endcase
                if (stage < STAGE_DROGUE)
                    apogee = pos;
                if (stage > STAGE_PAD && stage < STAGE_LANDED &&
                    elapsed > limits.backup_timeout_ms) begin
                    stage = STAGE_LANDED;
                    mode  = MODE_GROUND;
                end
            end
            r.stage            = stage;
            r.since_launch_ms  = elapsed;
            r.apogee           = apogee;
            r.record_mode      = mode;
            r.launch_indicator = indicator;
            r.frozen           = is_frozen();
            return r;
        endfunction

        function void note_tick(t_in_item tick);
            awaited.push_back(advance_flight(tick));
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("ERROR: %s", msg);
            errors++;
        endtask

        task match_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d, %s: got %0h, expected %0h", seen, name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            seen++;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d arrived with no transfer outstanding", seen));
            end else begin
                want = awaited.pop_front();
                match_field("stage", got.stage, want.stage);
                match_field("since_launch_ms", got.since_launch_ms, want.since_launch_ms);
                match_field("apogee", got.apogee, want.apogee);
                match_field("record_mode", got.record_mode, want.record_mode);
                match_field("launch_indicator", got.launch_indicator, want.launch_indicator);
                match_field("frozen", got.frozen, want.frozen);
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_item              i_in;
    logic                  o_valid;
    logic                  i_stall;
    t_out_item             o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    flight_tracker tracker;
    logic [31:0]   clock_ms;
    int            sent;
    bit            calm;

    flight_phase_detector i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm || $urandom_range(0, 3) != 0) begin
                i_stall = 1'b0;
            end else begin
                i_stall = 1'b1;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result(o_out);
    end

    function automatic int near(int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    function automatic longint pick_value(longint lo, longint hi, longint dflt);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            2: return dflt;
            default: return lo + longint'($urandom_range(0, 32'(hi - lo)));
        endcase
    endfunction

    function automatic t_cfg pick_limits();
        t_cfg c;
        c.launch_accel_limit   = 17'(pick_value(0, 100000, 1900));
        c.coast_accel_limit    = 17'(pick_value(0, 100000, 500));
        c.main_deploy_altitude = 24'(pick_value(0, 10000000, 25000));
        c.landing_altitude     = 24'(pick_value(0, 10000000, 2000));
        c.landing_velocity     = 18'(pick_value(-100000, 0, -50));
        c.landing_hold_ticks   = 8'(pick_value(0, 255, 50));
        c.backup_timeout_ms    = 32'(pick_value(0, 64'hFFFF_FFFF, 180000000));
        c.min_fix_quality      = 4'(pick_value(0, 15, 4));
        return c;
    endfunction

    function automatic t_in_item make_tick(logic [31:0] t, int raw, int acc, int vel,
                                           int pos, int baro, logic [3:0] fix);
        t_in_item k;
        k.time_ms     = t;
        k.raw_accel_z = 24'(raw);
        k.accel_z     = 24'(acc);
        k.vel_z       = 24'(vel);
        k.pos_z       = pos;
        k.baro_alt    = baro;
        k.fix_quality = fix;
        return k;
    endfunction

    function automatic t_in_item noisy_tick();
        return make_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         4'($urandom));
    endfunction

    // Random pad traffic that is kept just short of the launch gate.
    function automatic t_in_item pad_tick();
        t_in_item k;
        k = noisy_tick();
        if ($signed(k.raw_accel_z) > int'(tracker.limits.launch_accel_limit) &&
            k.fix_quality > tracker.limits.min_fix_quality) begin
            if ($urandom_range(0, 1))
                k.fix_quality = 4'($urandom_range(0, tracker.limits.min_fix_quality));
            else
                k.raw_accel_z = 24'(int'(tracker.limits.launch_accel_limit) -
                                    int'($urandom_range(0, 5000)));
        end
        return k;
    endfunction

    // Moves time forward, now and then backward, and puts the gate of the current stage
    // near its threshold so that transitions happen after a few ticks.
    function automatic t_in_item flight_tick();
        t_in_item k;
        if ($urandom_range(0, 24) == 0)
            clock_ms = clock_ms - $urandom_range(1, 3000);
        else
            clock_ms = clock_ms + $urandom_range(0, 1500);
        k = make_tick(clock_ms, near(300000), near(300000), near(300000), $urandom, $urandom,
                      4'($urandom_range(0, 15)));
        case (tracker.stage)
            STAGE_PAD: begin
                if ($urandom_range(0, 3) == 0) begin
                    k.raw_accel_z = 24'(int'(tracker.limits.launch_accel_limit) + 1 +
                                        int'($urandom_range(0, 1000)));
                    k.fix_quality = 4'($urandom_range(tracker.limits.min_fix_quality + 1, 15));
                end else begin
                    k.fix_quality = 4'($urandom_range(0, tracker.limits.min_fix_quality));
                end
            end
            STAGE_BOOST:  k.accel_z = 24'(int'(tracker.limits.coast_accel_limit) + near(5000));
            STAGE_COAST:  k.vel_z = 24'(near(5000));
            STAGE_DROGUE: k.pos_z = int'(tracker.limits.main_deploy_altitude) + near(50000);
            STAGE_MAIN: begin
                k.vel_z    = 24'(int'(tracker.limits.landing_velocity) + near(5000));
                k.baro_alt = int'(tracker.limits.landing_altitude) + near(50000);
            end
            default: ;
        endcase
        return k;
    endfunction

    task automatic send_tick(input t_in_item k);
        i_in    = k;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_tick(k);
        sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        tracker.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic load_limits(input t_cfg c);
        put_reg(CFG_LAUNCH_ACCEL, 32'(c.launch_accel_limit));
        put_reg(CFG_COAST_ACCEL, 32'(c.coast_accel_limit));
        put_reg(CFG_MAIN_ALT, 32'(c.main_deploy_altitude));
        put_reg(CFG_LAND_ALT, 32'(c.landing_altitude));
        put_reg(CFG_LAND_VEL, 32'(c.landing_velocity));
        put_reg(CFG_HOLD_TICKS, 32'(c.landing_hold_ticks));
        put_reg(CFG_BACKUP_MS, c.backup_timeout_ms);
        put_reg(CFG_MIN_FIX, 32'(c.min_fix_quality));
        i_cfg_we = 1'b0;
    endtask

    initial begin
        t_cfg c;
        int   n;
        int   i32_max;
        int   i32_min;
        tracker    = new();
        i32_max    = 32'h7FFF_FFFF;
        i32_min    = 32'h8000_0000;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        calm       = 1'b0;
        sent       = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Pad stage at reset limits: field extremes, both sides of the launch gates,
        // the indicator window after power-up and time stepping backward.
        send_tick(make_tick(32'd0, 0, 0, 0, 0, 0, 4'd0));
        send_tick(make_tick(32'd1, 8388607, 8388607, 8388607, i32_max, i32_max, 4'd4));
        send_tick(make_tick(32'd1000, 1901, -1, -1, -1, -1, 4'd4));
        send_tick(make_tick(32'd1999, 1900, 0, 0, 0, 0, 4'd15));
        send_tick(make_tick(32'd2000, -8388608, -8388608, -8388608, i32_min, i32_min, 4'd15));
        send_tick(make_tick(32'd2001, 0, 5, 5, 5, 5, 4'd5));
        send_tick(make_tick(32'hFFFF_FFFF, -1, -1, -1, -1, -1, 4'd15));
        send_tick(make_tick(32'h8000_0000, 1900, 1, 1, 1, 1, 4'd15));
        send_tick(make_tick(32'd3, 1900, 2, 2, 2, 2, 4'd5));
        send_tick(make_tick(32'd4, -5, -5, -5, -5, -5, 4'd9));
        settle();

        c = pick_limits();
        c.launch_accel_limit = 17'd0;
        c.min_fix_quality    = 4'd15;
        load_limits(c);
        repeat (300) send_tick(noisy_tick());
        settle();

        c = pick_limits();
        c.launch_accel_limit = 17'd100000;
        c.min_fix_quality    = 4'd0;
        load_limits(c);
        repeat (100) send_tick(pad_tick());
        settle();

        load_limits(pick_limits());
        repeat (100) send_tick(pad_tick());
        settle();

        c = pick_limits();
        if (c.min_fix_quality == 4'd15)
            c.min_fix_quality = 4'($urandom_range(0, 14));
        c.landing_hold_ticks = 8'($urandom_range(0, 60));
        if ($urandom_range(0, 1))
            c.backup_timeout_ms = $urandom_range(0, 40000);
        else if ($urandom_range(0, 1))
            c.backup_timeout_ms = 32'hFFFF_FFFF;
        else
            c.backup_timeout_ms = 32'd180000000;
        load_limits(c);
        clock_ms = $urandom_range(100000, 32'h7FFF_FFFF);
        n = 0;
        while (tracker.stage != STAGE_LANDED && n < 600) begin
            send_tick(flight_tick());
            n++;
        end
        n = 0;
        while (!tracker.is_frozen() && n < 300) begin
            send_tick(flight_tick());
            n++;
        end
        repeat (30) send_tick(flight_tick());
        settle();

        c = tracker.limits;
        c.landing_hold_ticks = 8'd255;
        load_limits(c);
        repeat (300) send_tick(flight_tick());
        settle();

        c.landing_hold_ticks = 8'd0;
        load_limits(c);
        repeat (20) send_tick(flight_tick());
        settle();

        calm = 1'b1;
        load_limits(pick_limits());
        n = 0;
        while (sent < 1400 || n < 50) begin
            send_tick(flight_tick());
            n++;
        end
        settle();
        repeat (10) @(negedge i_clk);

        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
